// ----- rtl/rivra_pkg.sv -----
// shared types, constants and the route function of the router input port
package rivra_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int COORD_WIDTH = 4;
  localparam int NUM_VC_DEF  = 4;
  localparam int VC_DEPTH_DEF = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [DATA_WIDTH-1:0]  data_t;

  typedef enum logic [0:0] {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    DIR_TILE = 3'd0,
    DIR_XP   = 3'd1,
    DIR_XM   = 3'd2,
    DIR_YP   = 3'd3,
    DIR_YM   = 3'd4
  } dir_t;

  localparam logic [CFG_IDX_W-1:0] REG_MY_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MY_Y = CFG_IDX_W'(1);

  typedef struct packed {
    mode_t      mode;
    data_t      flit_data;
    logic       active;
    coord_t     dest_x;
    coord_t     dest_y;
    logic       route_yx;
    logic [2:0] req_dir;
  } in_item_t;

  typedef struct packed {
    logic   ok;
    data_t  out_data;
    logic   out_active;
    coord_t out_dest_x;
    coord_t out_dest_y;
    logic   out_route_yx;
  } out_item_t;

  typedef struct packed {
    data_t  data;
    logic   act;
    coord_t dest_x;
    coord_t dest_y;
    logic   route_yx;
    dir_t   dir;
  } vc_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } vc_status_t;

  // dimension-order route: tile on match, else x then y (XY) or y then x (YX)
  function automatic dir_t route_of(input coord_t dx, input coord_t dy, input logic yx,
                                    input coord_t mx, input coord_t my);
    dir_t d;
    if (dx == mx && dy == my) begin
      d = DIR_TILE;
    end else if (!yx) begin
      if (mx < dx)      d = DIR_XP;
      else if (mx > dx) d = DIR_XM;
      else if (my < dy) d = DIR_YP;
      else              d = DIR_YM;
    end else begin
      if (my < dy)      d = DIR_YP;
      else if (my > dy) d = DIR_YM;
      else if (mx < dx) d = DIR_XP;
      else              d = DIR_XM;
    end
    return d;
  endfunction

endpackage

// ----- rtl/rivra_vc_fifo.sv -----
// one virtual-channel fifo with a registered head entry
module rivra_vc_fifo import rivra_pkg::*; #(
  parameter int DEPTH = VC_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  vc_entry_t  push_entry,
  input  logic       pop,
  output vc_entry_t  head_entry,
  output vc_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vc_entry_t        mem [DEPTH];
  vc_entry_t        head_entry_r;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
    end
    if (push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_entry;
    end
  end

  // read ahead at the next head; bypass when that slot is written this cycle
  always_ff @(posedge clk) begin
    if (push && tail_r == head_nxt) begin
      head_entry_r <= push_entry;
    end else begin
      head_entry_r <= mem[head_nxt];
    end
  end

  assign head_entry      = head_entry_r;
  assign status.full     = (count_r == CNT_FULL);
  assign status.nonempty = (count_r != '0);

endmodule

// ----- rtl/router_input_vc_route_arbiter.sv -----
// router input port: xy/yx route compute, vc fifos and round-robin dequeue
// an accepted start reaches out_strobe through the input register, then the result register
// throughput: one transaction per cycle; busy is never raised, work sits between
//   the input register and the result register, the vc heads are registered reads
// reset clears coordinates, vc pointers, counts and the round-robin pointer;
//   fifo storage is not cleared; the receiver cannot stall
module router_input_vc_route_arbiter import rivra_pkg::*; #(
  parameter int NUM_VC   = NUM_VC_DEF,
  parameter int VC_DEPTH = VC_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int VC_W = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;
  localparam logic [VC_W-1:0] VC_LAST = VC_W'(NUM_VC - 1);

  coord_t     my_x_r, my_y_r;
  logic       in_vld_r;
  in_item_t   in_q_r;
  logic       out_strobe_r;
  out_item_t  out_item_r, out_item_nxt;
  logic [VC_W-1:0] rr_r, rr_nxt;

  vc_entry_t  head   [NUM_VC];
  vc_status_t stat   [NUM_VC];
  logic [NUM_VC-1:0] push_v, pop_v;
  vc_entry_t  new_entry;

  logic [NUM_VC-1:0] match_v, match_hi_v;
  logic              wr_found, rd_found, hi_found;
  logic [VC_W-1:0]   wr_idx, lo_idx, hi_idx, rd_idx;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_x_r <= '0;
      my_y_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MY_X) my_x_r <= cfg_data[COORD_WIDTH-1:0];
      if (cfg_index == REG_MY_Y) my_y_r <= cfg_data[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q_r <= in_item;
    end
  end

  always_comb begin
    new_entry.data     = in_q_r.flit_data;
    new_entry.act      = in_q_r.active;
    new_entry.dest_x   = in_q_r.dest_x;
    new_entry.dest_y   = in_q_r.dest_y;
    new_entry.route_yx = in_q_r.route_yx;
    new_entry.dir      = route_of(in_q_r.dest_x, in_q_r.dest_y, in_q_r.route_yx,
                                  my_x_r, my_y_r);
  end

  // lowest vc with room
  always_comb begin
    wr_found = 1'b0;
    wr_idx   = '0;
    for (int v = 0; v < NUM_VC; v++) begin
      if (!wr_found && !stat[v].full) begin
        wr_found = 1'b1;
        wr_idx   = VC_W'(v);
      end
    end
  end

  // heads that can go to the requested direction; search from rr_r upward first
  always_comb begin
    for (int v = 0; v < NUM_VC; v++) begin
      match_v[v]    = stat[v].nonempty && head[v].act &&
                      (3'(head[v].dir) == in_q_r.req_dir);
      match_hi_v[v] = match_v[v] && (VC_W'(v) >= rr_r);
    end
    rd_found = 1'b0;
    lo_idx   = '0;
    hi_found = 1'b0;
    hi_idx   = '0;
    for (int v = 0; v < NUM_VC; v++) begin
      if (!rd_found && match_v[v]) begin
        rd_found = 1'b1;
        lo_idx   = VC_W'(v);
      end
      if (!hi_found && match_hi_v[v]) begin
        hi_found = 1'b1;
        hi_idx   = VC_W'(v);
      end
    end
    rd_idx = hi_found ? hi_idx : lo_idx;
  end

  always_comb begin
    out_item_nxt = '0;
    push_v       = '0;
    pop_v        = '0;
    rr_nxt       = rr_r;
    if (in_vld_r) begin
      case (in_q_r.mode)
        MODE_WRITE: begin
          if (wr_found) begin
            push_v[wr_idx]  = 1'b1;
            out_item_nxt.ok = 1'b1;
          end
        end
        MODE_READ: begin
          if (rd_found) begin
            pop_v[rd_idx]             = 1'b1;
            out_item_nxt.ok           = 1'b1;
            out_item_nxt.out_data     = head[rd_idx].data;
            out_item_nxt.out_active   = head[rd_idx].act;
            out_item_nxt.out_dest_x   = head[rd_idx].dest_x;
            out_item_nxt.out_dest_y   = head[rd_idx].dest_y;
            out_item_nxt.out_route_yx = head[rd_idx].route_yx;
            rr_nxt = (rd_idx == VC_LAST) ? '0 : rd_idx + VC_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_VC; g++) begin : g_vc
    rivra_vc_fifo #(
      .DEPTH (VC_DEPTH)
    ) u_fifo (
      .clk        (clk),
      .rst_n      (rst_n),
      .push       (push_v[g]),
      .push_entry (new_entry),
      .pop        (pop_v[g]),
      .head_entry (head[g]),
      .status     (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      rr_r         <= '0;
    end else begin
      out_strobe_r <= in_vld_r;
      rr_r         <= rr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- rtl/rivra_checker.sv -----
// port-level checks for the router input port, bound to the top level
module rivra_checker import rivra_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_item,
  input logic                  out_strobe,
  input out_item_t             out_item
);

  // every accepted transaction gives exactly one result on out_strobe
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy && rst_n, 2) && $past(rst_n) |-> out_strobe)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, 2) && $past(rst_n))
    else $error("result without an accepted transaction");

  // a write returns only the ok flag
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_item.mode == MODE_WRITE, 2) |->
      out_item.out_data == '0 && !out_item.out_active && out_item.out_dest_x == '0 &&
      out_item.out_dest_y == '0 && !out_item.out_route_yx)
    else $error("write result carries flit fields");

  // a refused read or write returns zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.ok |->
      out_item.out_data == '0 && !out_item.out_active && out_item.out_dest_x == '0 &&
      out_item.out_dest_y == '0 && !out_item.out_route_yx)
    else $error("refused result carries flit fields");

  // direction codes beyond the five ports never match
  a_bad_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_item.mode == MODE_READ && in_item.req_dir > 3'(DIR_YM), 2)
      |-> !out_item.ok)
    else $error("read of an unused direction dequeued a flit");

endmodule

bind router_input_vc_route_arbiter rivra_checker u_rivra_checker (.*);

// ----- test/router_input_vc_route_arbiter_test.sv -----
// self-checking testbench for the router input port: route compute, vc fifos, rr dequeue
module router_input_vc_route_arbiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rivra_pkg::*;

  localparam int NUM_VC   = NUM_VC_DEF;
  localparam int VC_DEPTH = VC_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 305;
  // unused register index, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  class route_scoreboard;
    coord_t      my_x = '0;
    coord_t      my_y = '0;
    vc_entry_t   fifo [NUM_VC][VC_DEPTH];
    int unsigned rd_ptr [NUM_VC];
    int unsigned wr_ptr [NUM_VC];
    int unsigned fill [NUM_VC];
    int unsigned rr_next;
    out_item_t   expected_q [$];
    int unsigned fail_count;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MY_X) my_x = val[COORD_WIDTH-1:0];
      else if (idx == REG_MY_Y) my_y = val[COORD_WIDTH-1:0];
    endfunction

    function dir_t route_for(coord_t dx, coord_t dy, logic yx);
      if (dx == my_x && dy == my_y) return DIR_TILE;
      if (!yx) begin
        if (my_x < dx) return DIR_XP;
        if (my_x > dx) return DIR_XM;
        if (my_y < dy) return DIR_YP;
        return DIR_YM;
      end
      if (my_y < dy) return DIR_YP;
      if (my_y > dy) return DIR_YM;
      if (my_x < dx) return DIR_XP;
      return DIR_XM;
    endfunction

    function bit all_full();
      for (int i = 0; i < NUM_VC; i++)
        if (fill[i] < VC_DEPTH) return 1'b0;
      return 1'b1;
    endfunction

    // direction of some active head flit, so reads mostly hit
    function logic [2:0] head_dir_pick();
      logic [2:0] opts [$];
      for (int i = 0; i < NUM_VC; i++)
        if (fill[i] != 0 && fifo[i][rd_ptr[i]].act) opts.push_back(3'(fifo[i][rd_ptr[i]].dir));
      if (opts.size() == 0) return 3'($urandom_range(7));
      return opts[$urandom_range(opts.size() - 1)];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      vc_entry_t e;
      int unsigned v;
      bit done;
      r = '0;
      done = 1'b0;
      if (it.mode == MODE_WRITE) begin
        for (int i = 0; i < NUM_VC; i++) begin
          if (!done && fill[i] < VC_DEPTH) begin
            e.data     = it.flit_data;
            e.act      = it.active;
            e.dest_x   = it.dest_x;
            e.dest_y   = it.dest_y;
            e.route_yx = it.route_yx;
            e.dir      = route_for(it.dest_x, it.dest_y, it.route_yx);
            fifo[i][wr_ptr[i]] = e;
            wr_ptr[i] = (wr_ptr[i] + 1) % VC_DEPTH;
            fill[i]++;
            r.ok = 1'b1;
            done = 1'b1;
          end
        end
      end else begin
        for (int k = 0; k < NUM_VC; k++) begin
          v = (rr_next + k) % NUM_VC;
          if (!done && fill[v] != 0) begin
            e = fifo[v][rd_ptr[v]];
            if (e.act && 3'(e.dir) == it.req_dir) begin
              r.ok           = 1'b1;
              r.out_data     = e.data;
              r.out_active   = e.act;
              r.out_dest_x   = e.dest_x;
              r.out_dest_y   = e.dest_y;
              r.out_route_yx = e.route_yx;
              rd_ptr[v] = (rd_ptr[v] + 1) % VC_DEPTH;
              fill[v]--;
              rr_next = (v + 1) % NUM_VC;
              done = 1'b1;
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [DATA_WIDTH-1:0] want, logic [DATA_WIDTH-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      check_field("ok", DATA_WIDTH'(want.ok), DATA_WIDTH'(got.ok));
      check_field("out_data", want.out_data, got.out_data);
      check_field("out_active", DATA_WIDTH'(want.out_active), DATA_WIDTH'(got.out_active));
      check_field("out_dest_x", DATA_WIDTH'(want.out_dest_x), DATA_WIDTH'(got.out_dest_x));
      check_field("out_dest_y", DATA_WIDTH'(want.out_dest_y), DATA_WIDTH'(got.out_dest_y));
      check_field("out_route_yx", DATA_WIDTH'(want.out_route_yx),
                  DATA_WIDTH'(got.out_route_yx));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  route_scoreboard sb = new();
  bit              idle_enable = 1'b1;
  int unsigned     cycle_count;

  router_input_vc_route_arbiter uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_item(input in_item_t it);
    while (idle_enable && $urandom_range(99) < 31) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper data bits are random and must be dropped
  task automatic set_coords(input coord_t x, input coord_t y);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom();
    d[COORD_WIDTH-1:0] = x;
    write_reg(REG_MY_X, d);
    d = $urandom();
    d[COORD_WIDTH-1:0] = y;
    write_reg(REG_MY_Y, d);
    write_reg(REG_SPARE, $urandom());
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t make_write(data_t data, logic act, coord_t dx, coord_t dy,
                                          logic yx);
    in_item_t it;
    it.mode      = MODE_WRITE;
    it.flit_data = data;
    it.active    = act;
    it.dest_x    = dx;
    it.dest_y    = dy;
    it.route_yx  = yx;
    it.req_dir   = 3'($urandom());
    return it;
  endfunction

  function automatic in_item_t random_item(int write_pct, int inactive_pct);
    in_item_t it;
    it.flit_data = $urandom();
    it.active    = ($urandom_range(99) >= inactive_pct);
    // bias destinations toward this router's row and column
    it.dest_x    = ($urandom_range(3) == 0) ? sb.my_x : coord_t'($urandom());
    it.dest_y    = ($urandom_range(3) == 0) ? sb.my_y : coord_t'($urandom());
    it.route_yx  = 1'($urandom_range(1));
    if ($urandom_range(99) < write_pct) begin
      it.mode    = MODE_WRITE;
      it.req_dir = 3'($urandom());
    end else begin
      it.mode    = MODE_READ;
      it.req_dir = ($urandom_range(9) < 7) ? sb.head_dir_pick() : 3'($urandom());
    end
    return it;
  endfunction

  task automatic run_random(input int count, input int inactive_pct);
    int write_pct;
    write_pct = 50;
    for (int n = 0; n < count; n++) begin
      // switch at random between fill-heavy, balanced and drain-heavy stretches
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: write_pct = 80;
          1: write_pct = 50;
          default: write_pct = 25;
        endcase
      end
      send_item(random_item(write_pct, inactive_pct));
    end
  endtask

  initial begin
    dir_t     dir_list [5];
    in_item_t rd;
    coord_t   px [6];
    coord_t   py [6];

    dir_list = '{DIR_TILE, DIR_XP, DIR_XM, DIR_YP, DIR_YM};
    px = '{'0, '1, '0, '1, coord_t'($urandom()), coord_t'($urandom())};
    py = '{'0, '1, '1, '0, coord_t'($urandom()), coord_t'($urandom())};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_coords(4'd5, 4'd9);
    // every route outcome under XY order, every move direction under YX order
    send_item(make_write('1, 1'b1, 4'd5, 4'd9, 1'b0));
    send_item(make_write('0, 1'b1, 4'd15, 4'd9, 1'b0));
    send_item(make_write(32'haaaaaaaa, 1'b1, 4'd0, 4'd0, 1'b0));
    send_item(make_write(32'h55555555, 1'b1, 4'd5, 4'd15, 1'b0));
    send_item(make_write(32'h12345678, 1'b1, 4'd5, 4'd0, 1'b0));
    send_item(make_write($urandom(), 1'b1, 4'd0, 4'd15, 1'b1));
    send_item(make_write($urandom(), 1'b1, 4'd15, 4'd0, 1'b1));
    send_item(make_write($urandom(), 1'b1, 4'd15, 4'd9, 1'b1));
    send_item(make_write($urandom(), 1'b1, 4'd0, 4'd9, 1'b1));
    // directions with no meaning never match
    for (int d = int'(DIR_YM) + 1; d < 8; d++) begin
      rd = random_item(0, 0);
      rd.req_dir = 3'(d);
      send_item(rd);
    end
    foreach (dir_list[i]) begin
      rd = random_item(0, 0);
      rd.req_dir = 3'(dir_list[i]);
      send_item(rd);
    end
    // fill every vc, then one write that must be refused
    while (!sb.all_full()) send_item(random_item(100, 0));
    send_item(random_item(100, 0));

    for (int p = 0; p < 6; p++) begin
      drain();
      set_coords(px[p], py[p]);
      idle_enable = (p != 1);
      // inactive flits block their vc for good, so only in the last phase
      run_random(ITEMS_PER_PHASE, (p == 5) ? 10 : 0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
